[src/hermite_fractional_delay_line_macros.svh]
// Assertion macros used by the top level of the fractional delay line RTL.
`ifndef HERMITE_FRACTIONAL_DELAY_LINE_MACROS_SVH
`define HERMITE_FRACTIONAL_DELAY_LINE_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define HFDL_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold after a trigger, as a non-overlapping implication.
`define HFDL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HFDL_ASSERT_HOLDS(label, cond, msg)
`define HFDL_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[src/hfdl_pkg.sv]
// Package of types, constants and the Hermite weight table for the fractional delay line.
`default_nettype none

package hfdl_pkg;

    localparam int FRACTION_BITS    = 8;
    localparam int DELAY_INT_BITS   = 11;
    localparam int DELAY_BITS       = DELAY_INT_BITS + FRACTION_BITS;
    localparam int FRAC_STEPS       = 1 << FRACTION_BITS;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 3;
    localparam int ROUND_SHIFT      = WEIGHT_FRAC_BITS + 1;
    localparam int TAPS             = 4;
    localparam int TAP_W            = 2;
    localparam int PC_W             = 3;

    typedef logic [FRACTION_BITS-1:0]                      frac_t;
    typedef logic [TAP_W-1:0]                              tap_sel_t;
    typedef logic [PC_W-1:0]                               pc_t;
    typedef logic signed [WEIGHT_W-1:0]                    weight_t;
    typedef logic [FRAC_STEPS-1:0][TAPS-1:0][WEIGHT_W-1:0] weight_tab_t;

    typedef enum logic [1:0] {
        MEM_IDLE,
        MEM_READ,
        MEM_WRITE
    } mem_op_t;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD
    } mac_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_ALWAYS,
        JMP_NO_REQ,
        JMP_PLAIN,
        JMP_OUT_BUSY
    } jump_t;

    // One microcode word.
    typedef struct packed {
        logic     take_req;
        mem_op_t  mem_op;
        tap_sel_t tap;
        mac_op_t  mac_op;
        tap_sel_t wsel;
        logic     finish;
        jump_t    jump;
        pc_t      target;
    } ucode_t;

    // Conditions the sequencer branches on.
    typedef struct packed {
        logic req_valid;
        logic plain;
        logic out_free;
    } seq_status_t;

    // Scales a weight held in units of 1/T^3 to WEIGHT_FRAC_BITS, rounding half up.
    function automatic longint to_weight(longint a);
        if (3 * FRACTION_BITS > WEIGHT_FRAC_BITS) begin
            return (a + (longint'(1) << (3 * FRACTION_BITS - WEIGHT_FRAC_BITS - 1)))
                   >>> (3 * FRACTION_BITS - WEIGHT_FRAC_BITS);
        end
        return a <<< (WEIGHT_FRAC_BITS - 3 * FRACTION_BITS);
    endfunction

    // Catmull-Rom weights, doubled, for every fraction step, built at elaboration.
    function automatic weight_tab_t build_weights();
        weight_tab_t tab;
        longint      t;
        longint      tt;
        longint      t2;
        longint      t3;
        longint      a [TAPS];
        int          i;
        int          k;
        tab = '0;
        tt  = longint'(FRAC_STEPS);
        for (i = 0; i < FRAC_STEPS; i++) begin
            t    = longint'(i);
            t2   = t * t;
            t3   = t2 * t;
            a[0] = -t3 + 2 * t2 * tt - t * tt * tt;
            a[1] = 3 * t3 - 5 * t2 * tt + 2 * tt * tt * tt;
            a[2] = -3 * t3 + 4 * t2 * tt + t * tt * tt;
            a[3] = t3 - t2 * tt;
            for (k = 0; k < TAPS; k++) begin
                tab[i][k] = WEIGHT_W'(to_weight(a[k]));
            end
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

    function automatic weight_t hermite_weight(frac_t t, tap_sel_t k);
        return weight_t'(WEIGHT_TAB[t][k]);
    endfunction

endpackage

`default_nettype wire

[src/hfdl_channels.sv]
// Request channels carrying samples into and delayed samples out of the delay line.
`default_nettype none

interface hfdl_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       sample_in;
    logic [hfdl_pkg::DELAY_BITS-1:0]     delay_amount;
    logic                                interpolate;

    modport source (output valid, sample_in, delay_amount, interpolate, input ready);
    modport sink   (input valid, sample_in, delay_amount, interpolate, output ready);
endinterface

interface hfdl_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          delay_clamped;

    modport source (output valid, sample_out, delay_clamped, input ready);
    modport sink   (input valid, sample_out, delay_clamped, output ready);
endinterface

`default_nettype wire

[src/hfdl_sequencer.sv]
// Microcode sequencer: step counter, control store and conditional jumps.
`default_nettype none

module hfdl_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hfdl_pkg::seq_status_t status,
    output hfdl_pkg::ucode_t      ctrl
);

    localparam hfdl_pkg::pc_t STEP_IDLE        = 3'd0;
    localparam hfdl_pkg::pc_t STEP_TAP0        = 3'd1;
    localparam hfdl_pkg::pc_t STEP_TAP1        = 3'd2;
    localparam hfdl_pkg::pc_t STEP_TAP2        = 3'd3;
    localparam hfdl_pkg::pc_t STEP_TAP3        = 3'd4;
    localparam hfdl_pkg::pc_t STEP_WRITE_MIX   = 3'd5;
    localparam hfdl_pkg::pc_t STEP_WRITE_PLAIN = 3'd6;
    localparam hfdl_pkg::pc_t STEP_FINISH      = 3'd7;

    hfdl_pkg::pc_t pc_reg;
    hfdl_pkg::pc_t pc_next;
    logic          taken;

    // Control store. Later read steps feed the MAC the tap fetched on the step before.
    always_comb
    begin
        case (pc_reg)
            STEP_IDLE:
                ctrl = '{take_req: 1'b1, mem_op: hfdl_pkg::MEM_IDLE, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_HOLD, wsel: 2'd0, finish: 1'b0,
                         jump: hfdl_pkg::JMP_NO_REQ, target: STEP_IDLE};
            STEP_TAP0:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_READ, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_HOLD, wsel: 2'd0, finish: 1'b0,
                         jump: hfdl_pkg::JMP_PLAIN, target: STEP_WRITE_PLAIN};
            STEP_TAP1:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_READ, tap: 2'd1,
                         mac_op: hfdl_pkg::MAC_LOAD, wsel: 2'd0, finish: 1'b0,
                         jump: hfdl_pkg::JMP_NEXT, target: STEP_IDLE};
            STEP_TAP2:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_READ, tap: 2'd2,
                         mac_op: hfdl_pkg::MAC_ADD, wsel: 2'd1, finish: 1'b0,
                         jump: hfdl_pkg::JMP_NEXT, target: STEP_IDLE};
            STEP_TAP3:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_READ, tap: 2'd3,
                         mac_op: hfdl_pkg::MAC_ADD, wsel: 2'd2, finish: 1'b0,
                         jump: hfdl_pkg::JMP_NEXT, target: STEP_IDLE};
            STEP_WRITE_MIX:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_WRITE, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_ADD, wsel: 2'd3, finish: 1'b0,
                         jump: hfdl_pkg::JMP_ALWAYS, target: STEP_FINISH};
            STEP_WRITE_PLAIN:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_WRITE, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_HOLD, wsel: 2'd0, finish: 1'b0,
                         jump: hfdl_pkg::JMP_NEXT, target: STEP_IDLE};
            STEP_FINISH:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_IDLE, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_HOLD, wsel: 2'd0, finish: 1'b1,
                         jump: hfdl_pkg::JMP_OUT_BUSY, target: STEP_FINISH};
            default:
                ctrl = '{take_req: 1'b0, mem_op: hfdl_pkg::MEM_IDLE, tap: 2'd0,
                         mac_op: hfdl_pkg::MAC_HOLD, wsel: 2'd0, finish: 1'b0,
                         jump: hfdl_pkg::JMP_ALWAYS, target: STEP_IDLE};
        endcase
    end

    always_comb
    begin
        case (ctrl.jump)
            hfdl_pkg::JMP_NEXT:     taken = 1'b0;
            hfdl_pkg::JMP_ALWAYS:   taken = 1'b1;
            hfdl_pkg::JMP_NO_REQ:   taken = !status.req_valid;
            hfdl_pkg::JMP_PLAIN:    taken = status.plain;
            hfdl_pkg::JMP_OUT_BUSY: taken = !status.out_free;
            default:                taken = 1'b0;
        endcase
        // The last step falls through to the idle step by wrapping the counter.
        pc_next = taken ? ctrl.target : pc_reg + hfdl_pkg::pc_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

[src/hfdl_ring.sv]
// Circular sample store with tap addressing and fill tracking.
`default_nettype none

module hfdl_ring #(
    parameter int RING_DEPTH  = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hfdl_pkg::ucode_t                ctrl,
    input  logic [$clog2(RING_DEPTH)-1:0]   base,
    input  logic signed [SAMPLE_BITS-1:0]   wr_sample,
    output logic signed [SAMPLE_BITS-1:0]   rd_sample
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(RING_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_WIDE = (ADDR_W + 1)'(RING_DEPTH);

    logic signed [SAMPLE_BITS-1:0] mem [RING_DEPTH];

    logic [ADDR_W-1:0]             write_slot_reg;
    logic [ADDR_W-1:0]             write_slot_next;
    logic                          wrapped_reg;
    logic                          wrapped_next;
    logic signed [SAMPLE_BITS-1:0] rd_q_reg;
    logic                          rd_ok_reg;

    logic [ADDR_W-1:0] tap_dist;
    logic [ADDR_W:0]   diff;
    logic [ADDR_W-1:0] rd_addr;
    logic              written;
    logic              rd_en;
    logic              wr_en;

    assign rd_en = (ctrl.mem_op == hfdl_pkg::MEM_READ);
    assign wr_en = (ctrl.mem_op == hfdl_pkg::MEM_WRITE);

    // Slot at the given distance behind the write slot, modulo the ring depth.
    always_comb
    begin
        tap_dist = base + ADDR_W'(ctrl.tap);
        diff     = {1'b0, write_slot_reg} - {1'b0, tap_dist};
        if (diff[ADDR_W])
        begin
            rd_addr = ADDR_W'(diff + DEPTH_WIDE);
        end
        else
        begin
            rd_addr = diff[ADDR_W-1:0];
        end
        // Slots fill in order from reset, so those not yet reached still read as zero.
        written = wrapped_reg || (rd_addr < write_slot_reg);
    end

    always_comb
    begin
        write_slot_next = write_slot_reg;
        wrapped_next    = wrapped_reg;
        if (wr_en)
        begin
            if (write_slot_reg == LAST_SLOT)
            begin
                write_slot_next = '0;
                wrapped_next    = 1'b1;
            end
            else
            begin
                write_slot_next = write_slot_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            wrapped_reg    <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            wrapped_reg    <= wrapped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[write_slot_reg] <= wr_sample;
        end
        if (rd_en)
        begin
            rd_q_reg  <= mem[rd_addr];
            rd_ok_reg <= written;
        end
    end

    assign rd_sample = rd_ok_reg ? rd_q_reg : '0;

endmodule

`default_nettype wire

[src/hfdl_mac.sv]
// Multiply-accumulate unit applying the Hermite weights, with rounding and saturation.
`default_nettype none

module hfdl_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  hfdl_pkg::ucode_t              ctrl,
    input  hfdl_pkg::frac_t               frac,
    input  logic signed [SAMPLE_BITS-1:0] tap_sample,
    output logic signed [SAMPLE_BITS-1:0] mixed
);

    localparam int PROD_W = hfdl_pkg::WEIGHT_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Y_W    = ACC_W - hfdl_pkg::ROUND_SHIFT;
    localparam logic signed [ACC_W-1:0] HALF_LSB =
        ACC_W'(longint'(1) << (hfdl_pkg::ROUND_SHIFT - 1));
    localparam logic signed [Y_W-1:0] SAT_HI =
        Y_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Y_W-1:0] SAT_LO =
        Y_W'(-(longint'(1) << (SAMPLE_BITS - 1)));

    hfdl_pkg::weight_t       weight;
    logic signed [PROD_W-1:0] product;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [Y_W-1:0]    y_wide;

    always_comb
    begin
        weight  = hfdl_pkg::hermite_weight(frac, ctrl.wsel);
        product = PROD_W'(weight) * PROD_W'(tap_sample);
        case (ctrl.mac_op)
            hfdl_pkg::MAC_LOAD: acc_next = ACC_W'(product);
            hfdl_pkg::MAC_ADD:  acc_next = acc_reg + ACC_W'(product);
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Drop the weight scale and the halving together, rounding half up.
    always_comb
    begin
        rounded = acc_reg + HALF_LSB;
        y_wide  = rounded[ACC_W-1:hfdl_pkg::ROUND_SHIFT];
        if (y_wide > SAT_HI)
        begin
            mixed = SAMPLE_BITS'(SAT_HI);
        end
        else if (y_wide < SAT_LO)
        begin
            mixed = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            mixed = SAMPLE_BITS'(y_wide);
        end
    end

endmodule

`default_nettype wire

[src/hermite_fractional_delay_line.sv]
// Top level of the cubic Hermite interpolated fractional delay line.
//
// Samples arrive on the upstream channel, one request per audio sample, with a
// delay in samples (11 integer and 8 fraction bits) and an interpolate flag.
// Each request first reads the ring of past samples and then stores the new
// sample, so a delay of one returns the previous sample. Each request yields
// exactly one result on the downstream channel: the delayed sample, saturated,
// and a flag telling whether the delay had to be clamped to the legal range.
// In interpolate mode the program steps through idle, four tap reads, the
// mixed write and the finish step; in plain mode through idle, one tap read,
// the plain write and the finish step. A new request is taken only at idle;
// the single port of the sample store serves the reads and the write in turn.
// Reset clears the step counter, the write slot and the output valid flag. The
// ring needs no clearing pass: a slot not yet written since reset reads as zero.
// A finished result waits in the output register while the next request is
// already taken in; if the receiver still stalls when the following result is
// ready, the sequencer holds on its last step until the register is free.
`default_nettype none

`include "hermite_fractional_delay_line_macros.svh"

module hermite_fractional_delay_line #(
    parameter int RING_DEPTH  = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    hfdl_in_if.sink     upstream,
    hfdl_out_if.source  downstream
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CMP_W  =
        ((ADDR_W > hfdl_pkg::DELAY_INT_BITS) ? ADDR_W : hfdl_pkg::DELAY_INT_BITS) + 2;
    localparam int RND_W  = hfdl_pkg::DELAY_BITS + 1;

    localparam logic [CMP_W-1:0] D_MIN    = CMP_W'(2);
    localparam logic [CMP_W-1:0] D_MAX    = CMP_W'(RING_DEPTH - 3);
    localparam logic [CMP_W-1:0] R_MIN    = CMP_W'(1);
    localparam logic [CMP_W-1:0] R_MAX    = CMP_W'(RING_DEPTH - 1);
    localparam logic [RND_W-1:0] RND_HALF = RND_W'(hfdl_pkg::FRAC_STEPS / 2);

    hfdl_pkg::ucode_t      ctrl;
    hfdl_pkg::seq_status_t status;

    logic accept;
    logic out_free;
    logic load_out;

    // Delay decoding for the request on the upstream channel.
    logic [CMP_W-1:0] d_wide;
    logic [RND_W-1:0] rnd_sum;
    logic [CMP_W-1:0] r_wide;
    logic [CMP_W-1:0] base_wide;

    // Request held for the duration of its program.
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic [ADDR_W-1:0]             base_reg;
    logic [ADDR_W-1:0]             base_next;
    hfdl_pkg::frac_t               frac_reg;
    hfdl_pkg::frac_t               frac_next;
    logic                          plain_reg;
    logic                          plain_next;
    logic                          clamp_reg;
    logic                          clamp_next;

    // Output register.
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;
    logic                          out_clamp_reg;
    logic                          out_clamp_next;

    logic signed [SAMPLE_BITS-1:0] tap_sample;
    logic signed [SAMPLE_BITS-1:0] mixed_sample;

    assign upstream.ready = ctrl.take_req;
    assign accept         = upstream.valid && upstream.ready;
    assign out_free       = !out_valid_reg || downstream.ready;
    assign load_out       = ctrl.finish && out_free;

    assign status = '{req_valid: upstream.valid, plain: plain_reg, out_free: out_free};

    hfdl_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    hfdl_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .base      (base_reg),
        .wr_sample (sample_reg),
        .rd_sample (tap_sample)
    );

    hfdl_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk        (clk),
        .ctrl       (ctrl),
        .frac       (frac_reg),
        .tap_sample (tap_sample),
        .mixed      (mixed_sample)
    );

    // The base distance is the nearest tap: d-1 when interpolating, the rounded
    // delay otherwise. The program adds 0 to 3 to it for the four Hermite taps.
    always_comb
    begin
        d_wide    = CMP_W'(upstream.delay_amount[hfdl_pkg::DELAY_BITS-1:hfdl_pkg::FRACTION_BITS]);
        rnd_sum   = {1'b0, upstream.delay_amount} + RND_HALF;
        r_wide    = CMP_W'(rnd_sum[RND_W-1:hfdl_pkg::FRACTION_BITS]);
        frac_next = upstream.delay_amount[hfdl_pkg::FRACTION_BITS-1:0];
        clamp_next = 1'b0;
        if (upstream.interpolate)
        begin
            base_wide = d_wide - CMP_W'(1);
            // A clamped interpolating delay sits exactly on its bound, so the fraction is dropped.
            if (d_wide < D_MIN)
            begin
                base_wide  = D_MIN - CMP_W'(1);
                frac_next  = '0;
                clamp_next = 1'b1;
            end
            else if (d_wide > D_MAX)
            begin
                base_wide  = D_MAX - CMP_W'(1);
                frac_next  = '0;
                clamp_next = 1'b1;
            end
        end
        else
        begin
            base_wide = r_wide;
            if (r_wide < R_MIN)
            begin
                base_wide  = R_MIN;
                clamp_next = 1'b1;
            end
            else if (r_wide > R_MAX)
            begin
                base_wide  = R_MAX;
                clamp_next = 1'b1;
            end
        end
        base_next   = base_wide[ADDR_W-1:0];
        plain_next  = !upstream.interpolate;
        sample_next = upstream.sample_in;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample_next;
            base_reg   <= base_next;
            frac_reg   <= frac_next;
            clamp_reg  <= clamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_reg <= 1'b0;
        end
        else if (accept)
        begin
            plain_reg <= plain_next;
        end
    end

    // In plain mode the single tap is the result; it is always within range.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !downstream.ready;
        out_sample_next = out_sample_reg;
        out_clamp_next  = out_clamp_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_sample_next = plain_reg ? tap_sample : mixed_sample;
            out_clamp_next  = clamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sample_reg <= out_sample_next;
        out_clamp_reg  <= out_clamp_next;
    end

    assign downstream.valid         = out_valid_reg;
    assign downstream.sample_out    = out_sample_reg;
    assign downstream.delay_clamped = out_clamp_reg;

    `HFDL_ASSERT_NEXT(a_one_item_in_flight, accept, !upstream.ready, "request taken while busy")
    `HFDL_ASSERT_HOLDS(a_no_load_during_accept, !(load_out && accept), "result loaded while idle")
    `HFDL_ASSERT_NEXT(a_clamp_drops_fraction, accept && upstream.interpolate && clamp_next, frac_reg == '0, "clamped delay kept its fraction")
    `HFDL_ASSERT_HOLDS(a_result_from_program, !$rose(downstream.valid) || $past(load_out), "result without a finished program")
    `HFDL_ASSERT_HOLDS(a_plain_skips_mac, !(plain_reg && ctrl.mac_op != hfdl_pkg::MAC_HOLD), "plain request ran the mixer")

endmodule

`default_nettype wire

[tb/hermite_fractional_delay_line_tb.sv]
// Self-checking testbench for the cubic Hermite fractional delay line, with its scoreboard.
`default_nettype none

typedef struct {
    logic signed [15:0] sample;
    logic               clamped;
} delayed_sample_t;

// Keeps a shadow ring of past samples, works out the delayed sample for every
// accepted request, and checks the results in order against that prediction.
class ring_tap_scoreboard;
    localparam int DEPTH      = 2048;
    localparam int FRAC       = hfdl_pkg::FRACTION_BITS;
    localparam int RAW_SHIFT  = 3 * FRAC - 16;
    localparam int SUM_SHIFT  = 17;

    logic signed [15:0] ring [DEPTH];
    logic [10:0]        wr_slot;
    delayed_sample_t    pending_taps [$];
    int                 errors;

    function new();
        foreach (ring[i]) ring[i] = '0;
        wr_slot = '0;
        errors  = 0;
    endfunction

    // Catmull-Rom weight of tap k at fraction t, doubled, with 16 fraction bits.
    function longint catmull_weight(int k, longint t);
        longint fs;
        longint t2;
        longint t3;
        longint raw;
        fs = longint'(1) << FRAC;
        t2 = t * t;
        t3 = t2 * t;
        case (k)
            0:       raw = -t3 + 2 * t2 * fs - t * fs * fs;
            1:       raw = 3 * t3 - 5 * t2 * fs + 2 * fs * fs * fs;
            2:       raw = -3 * t3 + 4 * t2 * fs + t * fs * fs;
            default: raw = t3 - t2 * fs;
        endcase
        return (raw + (longint'(1) << (RAW_SHIFT - 1))) >>> RAW_SHIFT;
    endfunction

    function longint ring_tap(int distance);
        logic [10:0] idx;
        idx = wr_slot - 11'(distance);
        return longint'(ring[idx]);
    endfunction

    function delayed_sample_t predict_delayed_sample(logic [hfdl_pkg::DELAY_BITS-1:0] delay,
                                                     logic interp);
        delayed_sample_t res;
        int              whole;
        longint          t;
        longint          acc;
        longint          y;
        int              k;
        res.clamped = 1'b0;
        if (interp) begin
            whole = int'(delay[hfdl_pkg::DELAY_BITS-1:FRAC]);
            t     = longint'(delay[FRAC-1:0]);
            if (whole < 2) begin
                whole = 2;
                t = 0;
                res.clamped = 1'b1;
            end else if (whole > DEPTH - 3) begin
                whole = DEPTH - 3;
                t = 0;
                res.clamped = 1'b1;
            end
            acc = 0;
            for (k = 0; k < 4; k++) begin
                acc += catmull_weight(k, t) * ring_tap(whole - 1 + k);
            end
            y = (acc + (longint'(1) << (SUM_SHIFT - 1))) >>> SUM_SHIFT;
        end else begin
            whole = (int'(delay) + (1 << (FRAC - 1))) >> FRAC;
            if (whole < 1) begin
                whole = 1;
                res.clamped = 1'b1;
            end else if (whole > DEPTH - 1) begin
                whole = DEPTH - 1;
                res.clamped = 1'b1;
            end
            y = ring_tap(whole);
        end
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        res.sample = 16'(y);
        return res;
    endfunction

    function void note_request(logic signed [15:0] sample,
                               logic [hfdl_pkg::DELAY_BITS-1:0] delay, logic interp);
        pending_taps.push_back(predict_delayed_sample(delay, interp));
        ring[wr_slot] = sample;
        wr_slot       = wr_slot + 11'd1;
    endfunction

    function void check_result(logic signed [15:0] sample, logic clamped);
        delayed_sample_t exp_res;
        if (pending_taps.size() == 0) begin
            $display("%0t: result %0d/%0b arrived with no request outstanding",
                     $time, sample, clamped);
            errors++;
            return;
        end
        exp_res = pending_taps.pop_front();
        if (sample !== exp_res.sample) begin
            $display("%0t: sample_out expected %0d actual %0d", $time, exp_res.sample, sample);
            errors++;
        end
        if (clamped !== exp_res.clamped) begin
            $display("%0t: delay_clamped expected %0b actual %0b",
                     $time, exp_res.clamped, clamped);
            errors++;
        end
    endfunction

    function int outstanding();
        return pending_taps.size();
    endfunction
endclass

module hermite_fractional_delay_line_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_PCT     = 31;
    localparam int HOLD_CYCLES  = 80;

    logic clk;
    logic rst_n;

    hfdl_in_if  #(.SAMPLE_BITS(16)) req_ch ();
    hfdl_out_if #(.SAMPLE_BITS(16)) res_ch ();

    ring_tap_scoreboard sb;

    // Windows in which one side never idles, so back-to-back requests are seen.
    logic steady_tx;
    logic steady_rx;
    int   results_seen;
    int   hold_left;
    logic held_once;

    hermite_fractional_delay_line #(
        .RING_DEPTH (2048),
        .SAMPLE_BITS(16)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .upstream  (req_ch),
        .downstream(res_ch)
    );

    always #10 clk = ~clk;

    // Offers one request and waits for the edge at which it is accepted. Valid
    // is only lowered for an idle gap, so a request that follows straight on
    // keeps valid high without dropping it within the same time step.
    task automatic send_request(logic signed [15:0] sample,
                                logic [hfdl_pkg::DELAY_BITS-1:0] delay, logic interp);
        while (!steady_tx && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.sample_in    <= sample;
        req_ch.delay_amount <= delay;
        req_ch.interpolate  <= interp;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(sample, delay, interp);
    endtask

    function automatic logic signed [15:0] pick_sample();
        if ($urandom_range(9) < 2) begin
            case ($urandom_range(3))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Mostly short delays so that the taps land on samples actually written;
    // the rest cover the whole ring, the clamp boundaries and the full field.
    function automatic logic [hfdl_pkg::DELAY_BITS-1:0] pick_delay();
        int          sel;
        logic [10:0] whole;
        logic [7:0]  frac;
        sel  = $urandom_range(99);
        frac = 8'($urandom);
        if (sel < 55) begin
            whole = 11'($urandom_range(40));
        end else if (sel < 75) begin
            whole = 11'($urandom_range(2047));
        end else if (sel < 88) begin
            case ($urandom_range(7))
                0:       whole = 11'd0;
                1:       whole = 11'd1;
                2:       whole = 11'd2;
                3:       whole = 11'd3;
                4:       whole = 11'd2044;
                5:       whole = 11'd2045;
                6:       whole = 11'd2046;
                default: whole = 11'd2047;
            endcase
            case ($urandom_range(3))
                0:       frac = 8'd0;
                1:       frac = 8'd127;
                2:       frac = 8'd128;
                default: frac = 8'd255;
            endcase
        end else begin
            return hfdl_pkg::DELAY_BITS'($urandom);
        end
        return {whole, frac};
    endfunction

    // Receiver: checks every accepted result and decides the ready for the
    // next edge. Once, after a hundred results, it holds ready low for a long
    // stretch so that the output register fills and the input request stalls.
    initial begin
        res_ch.ready = 1'b0;
        results_seen = 0;
        hold_left    = 0;
        held_once    = 1'b0;
        steady_rx    = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.sample_out, res_ch.delay_clamped);
                results_seen++;
            end
            steady_rx = (results_seen >= 260) && (results_seen < 380);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (!held_once && results_seen >= 100) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= steady_rx || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Sender and the end of the run.
    initial begin
        int                              i;
        int                              k;
        logic signed [15:0]              hi;
        logic [hfdl_pkg::DELAY_BITS-1:0] delay;
        sb  = new();
        clk = 1'b0;
        rst_n = 1'b0;
        steady_tx           = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.sample_in    = '0;
        req_ch.delay_amount = '0;
        req_ch.interpolate  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: clamping at both ends in both modes, rounding at the
        // half step, the legal edges of the interpolate range, and overshoot
        // of the cubic beyond full scale in both directions.
        send_request(16'sh7FFF, 19'd0, 1'b0);
        send_request(16'sh8000, 19'd127, 1'b0);
        send_request(16'sh8000, 19'd128, 1'b0);
        send_request(16'sh7FFF, 19'd0, 1'b1);
        send_request(16'sh7FFF, 19'h001FF, 1'b1);
        send_request(16'sh8000, 19'd256, 1'b0);
        send_request(16'sh7FFF, 19'd384, 1'b0);
        send_request(16'sh7FFF, 19'd512, 1'b0);
        send_request(16'sh8000, 19'd640, 1'b0);
        send_request(16'sh0000, 19'd640, 1'b1);
        send_request(16'sh7FFF, 19'd256, 1'b0);
        send_request(16'sh8000, 19'd256, 1'b0);
        send_request(16'sh8000, 19'd256, 1'b0);
        send_request(16'sh7FFF, 19'd256, 1'b0);
        send_request(16'sh5555, 19'd640, 1'b1);
        send_request(16'shAAAA, {11'd2045, 8'd255}, 1'b1);
        send_request(16'sh0001, {11'd2046, 8'd0}, 1'b1);
        send_request(16'shFFFF, 19'h7FFFF, 1'b1);
        send_request(16'sh1234, {11'd2047, 8'd127}, 1'b0);
        send_request(16'shEDCB, {11'd2047, 8'd128}, 1'b0);
        send_request(16'sh7FFF, 19'h7FFFF, 1'b0);
        send_request(16'sh8000, {11'd2, 8'd0}, 1'b1);
        send_request(16'sh0100, {11'd5, 8'd1}, 1'b1);
        send_request(16'sh5555, 19'h55555, 1'b0);
        send_request(16'shAAAA, 19'h2AAAA, 1'b1);

        // Random part. Now and then a run of full-scale samples, two of one sign
        // between two of the other, is followed by an interpolated read across it,
        // to provoke saturation with random fractions.
        i = 0;
        while (i < RANDOM_ITEMS) begin
            steady_tx = (i >= 250) && (i < 360);
            if ($urandom_range(99) < 5) begin
                hi = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                send_request(~hi, pick_delay(), 1'($urandom));
                send_request(hi, pick_delay(), 1'($urandom));
                send_request(hi, pick_delay(), 1'($urandom));
                send_request(~hi, pick_delay(), 1'($urandom));
                k     = $urandom_range(3);
                delay = {11'(2 + k), 8'($urandom)};
                send_request(pick_sample(), delay, 1'b1);
                i += 5;
            end else begin
                send_request(pick_sample(), pick_delay(), ($urandom_range(9) < 6));
                i++;
            end
        end
        steady_tx = 1'b0;
        req_ch.valid <= 1'b0;

        // Drain, then keep watching for any stray result to show up.
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 700 requests.
    initial begin
        #4ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
